// ===== design/nearest_point_min_offset_search_assert.svh =====
// assertion macros used by the nearest point search select module
`ifndef NEAREST_POINT_MIN_OFFSET_SEARCH_ASSERT_SVH
`define NEAREST_POINT_MIN_OFFSET_SEARCH_ASSERT_SVH

// same-cycle implication, off during reset
`define NPMS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("npms assertion failed");

// next-cycle implication, off during reset
`define NPMS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("npms assertion failed");

`endif

// ===== design/npms_pkg.sv =====
// types and constants for the nearest point search with minimum offset
package npms_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int DIST_W      = 2 * COORD_WIDTH + 2;
    localparam int CFG_IDX_W   = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [DIFF_W-1:0]             t_mag;
    typedef logic [DIST_W-1:0]             t_dist;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_X      = 2'd0,
        REG_REF_Y      = 2'd1,
        REG_REF_Z      = 2'd2,
        REG_MIN_OFFSET = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   last_point;
    } t_in_word;

    typedef struct packed {
        logic   found;
        t_coord nearest_x;
        t_coord nearest_y;
        t_coord nearest_z;
    } t_out_word;

    typedef struct packed {
        t_dist  sq_x;
        t_dist  sq_y;
        t_dist  sq_z;
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        logic   last_point;
    } t_sq_word;

endpackage

// ===== design/nearest_point_min_offset_search.sv =====
// Nearest point search with a minimum offset. Set ref_x/ref_y/ref_z and
// min_offset through the write port, then stream candidate words; each is
// judged against the reference by squared distance, and a word marked
// last_point yields one result word (found flag plus the nearest accepted
// point, zeros if none) and starts a fresh search. One word is accepted
// every cycle unless stalled; the result word is built from its last word
// in this order: the input register feeds three squaring multipliers into
// a stage register, and the 50-bit sum and compares feed the result register.
// Input stalls only while a last word waits for a full result register to drain.
module nearest_point_min_offset_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [npms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [npms_pkg::COORD_WIDTH-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  npms_pkg::t_in_word                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output npms_pkg::t_out_word                 o_out_data
);

    npms_pkg::t_coord                r_ref_x;
    npms_pkg::t_coord                r_ref_y;
    npms_pkg::t_coord                r_ref_z;
    logic [npms_pkg::COORD_WIDTH-1:0] r_min_offset;
    npms_pkg::t_dist                 r_min_sq;
    npms_pkg::t_dist                 n_min_sq;
    logic                            w_sq_valid;
    logic                            w_sq_ready;
    npms_pkg::t_sq_word              w_sq_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x      <= '0;
            r_ref_y      <= '0;
            r_ref_z      <= '0;
            r_min_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                npms_pkg::REG_REF_X:      r_ref_x      <= i_cfg_data;
                npms_pkg::REG_REF_Y:      r_ref_y      <= i_cfg_data;
                npms_pkg::REG_REF_Z:      r_ref_z      <= i_cfg_data;
                npms_pkg::REG_MIN_OFFSET: r_min_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // squared offset follows the register in the next cycle, ahead of any word
    assign n_min_sq = npms_pkg::t_dist'(r_min_offset) * npms_pkg::t_dist'(r_min_offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_sq <= '0;
        end else begin
            r_min_sq <= n_min_sq;
        end
    end

    npms_sq_stage u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ref_x (r_ref_x),
        .i_ref_y (r_ref_y),
        .i_ref_z (r_ref_z),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_sq_valid),
        .i_ready (w_sq_ready),
        .o_data  (w_sq_data)
    );

    npms_select u_sel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_sq    (r_min_sq),
        .i_valid     (w_sq_valid),
        .o_ready     (w_sq_ready),
        .i_data      (w_sq_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/npms_sq_stage.sv =====
// input register and per-axis squared difference stage
module npms_sq_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  npms_pkg::t_coord   i_ref_x,
    input  npms_pkg::t_coord   i_ref_y,
    input  npms_pkg::t_coord   i_ref_z,
    input  logic               i_valid,
    output logic               o_ready,
    input  npms_pkg::t_in_word i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output npms_pkg::t_sq_word o_data
);

    logic               r_s1_valid;
    npms_pkg::t_in_word r_s1;
    logic               r_s2_valid;
    npms_pkg::t_sq_word r_s2;
    npms_pkg::t_sq_word n_s2;
    logic               w_s1_free;
    logic               w_s2_free;
    npms_pkg::t_mag     w_mag_x;
    npms_pkg::t_mag     w_mag_y;
    npms_pkg::t_mag     w_mag_z;

    function automatic npms_pkg::t_mag abs_diff(npms_pkg::t_coord a, npms_pkg::t_coord b);
        logic signed [npms_pkg::DIFF_W-1:0] d;
        d = npms_pkg::DIFF_W'(a) - npms_pkg::DIFF_W'(b);
        return d[npms_pkg::DIFF_W-1] ? npms_pkg::t_mag'(-d) : npms_pkg::t_mag'(d);
    endfunction

    assign w_s2_free = !r_s2_valid || i_ready;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_ready   = w_s1_free;

    assign w_mag_x = abs_diff(i_ref_x, r_s1.point_x);
    assign w_mag_y = abs_diff(i_ref_y, r_s1.point_y);
    assign w_mag_z = abs_diff(i_ref_z, r_s1.point_z);

    always_comb begin
        n_s2.sq_x       = npms_pkg::t_dist'(w_mag_x) * npms_pkg::t_dist'(w_mag_x);
        n_s2.sq_y       = npms_pkg::t_dist'(w_mag_y) * npms_pkg::t_dist'(w_mag_y);
        n_s2.sq_z       = npms_pkg::t_dist'(w_mag_z) * npms_pkg::t_dist'(w_mag_z);
        n_s2.point_x    = r_s1.point_x;
        n_s2.point_y    = r_s1.point_y;
        n_s2.point_z    = r_s1.point_z;
        n_s2.last_point = r_s1.last_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_valid) begin
            r_s1 <= i_data;
        end
        if (w_s2_free && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_data  = r_s2;

endmodule

// ===== design/npms_select.sv =====
// distance sum, nearest point tracking and result register
`include "nearest_point_min_offset_search_assert.svh"

module npms_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  npms_pkg::t_dist     i_min_sq,
    input  logic                i_valid,
    output logic                o_ready,
    input  npms_pkg::t_sq_word  i_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output npms_pkg::t_out_word o_out_data
);

    logic                r_have_best;
    npms_pkg::t_dist     r_best_dist;
    npms_pkg::t_coord    r_best_x;
    npms_pkg::t_coord    r_best_y;
    npms_pkg::t_coord    r_best_z;
    logic                r_out_valid;
    npms_pkg::t_out_word r_out;
    npms_pkg::t_out_word n_out;
    logic                w_out_free;
    logic                w_consume;
    npms_pkg::t_dist     w_dist;
    logic                w_keep;
    logic                w_found;

    assign w_out_free = !r_out_valid || i_out_ready;
    // only a last word needs room in the result register
    assign o_ready    = !i_data.last_point || w_out_free;
    assign w_consume  = i_valid && o_ready;

    assign w_dist  = i_data.sq_x + i_data.sq_y + i_data.sq_z;
    // strict compare keeps the earliest point on a tie
    assign w_keep  = (w_dist >= i_min_sq) && (!r_have_best || (w_dist < r_best_dist));
    assign w_found = w_keep || r_have_best;

    always_comb begin
        n_out.found = w_found;
        if (!w_found) begin
            n_out.nearest_x = '0;
            n_out.nearest_y = '0;
            n_out.nearest_z = '0;
        end else if (w_keep) begin
            n_out.nearest_x = i_data.point_x;
            n_out.nearest_y = i_data.point_y;
            n_out.nearest_z = i_data.point_z;
        end else begin
            n_out.nearest_x = r_best_x;
            n_out.nearest_y = r_best_y;
            n_out.nearest_z = r_best_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_consume) begin
                r_have_best <= i_data.last_point ? 1'b0 : w_found;
                if (i_data.last_point) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_keep) begin
            r_best_dist <= w_dist;
            r_best_x    <= i_data.point_x;
            r_best_y    <= i_data.point_y;
            r_best_z    <= i_data.point_z;
        end
        if (w_consume && i_data.last_point) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `NPMS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_consume && i_data.last_point, !r_have_best && r_out_valid)
    `NPMS_ASSERT_IMPLY(a_out_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_consume && i_data.last_point))
    `NPMS_ASSERT_IMPLY(a_none_is_zero, i_clk, i_rst_n, r_out_valid && !r_out.found, (r_out.nearest_x == '0) && (r_out.nearest_y == '0) && (r_out.nearest_z == '0))

endmodule

// ===== tb/sv/nearest_point_min_offset_search_test.sv =====
// self-checking testbench for the nearest point search with minimum offset
module nearest_point_min_offset_search_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        rst_n;
    logic        cfg_we;
    npms_pkg::t_cfg_reg cfg_index;
    logic [npms_pkg::COORD_WIDTH-1:0] cfg_data;
    logic        in_valid;
    logic        o_in_ready;
    npms_pkg::t_in_word in_data;
    logic        o_out_valid;
    logic        out_ready;
    npms_pkg::t_out_word o_out_data;

    // search predictor state and its copy of the registers
    npms_pkg::t_coord set_ref_x, set_ref_y, set_ref_z;
    logic [npms_pkg::COORD_WIDTH-1:0] set_min_offset;
    bit          kept_any;
    longint unsigned kept_dist;
    npms_pkg::t_coord kept_x, kept_y, kept_z;
    npms_pkg::t_out_word nearest_q[$];

    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          results_found = 0;
    int          cycle_count = 0;
    bit          gapless = 0;
    int          hold_off = 0;

    nearest_point_min_offset_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nearest_point_min_offset_search_test NOT OK");
            $finish;
        end
    end

    function automatic longint unsigned sq_offset(npms_pkg::t_coord a, npms_pkg::t_coord b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic npms_pkg::t_in_word make_word(npms_pkg::t_coord x, npms_pkg::t_coord y,
                                                     npms_pkg::t_coord z, logic last);
        npms_pkg::t_in_word w;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        w.last_point = last;
        return w;
    endfunction

    // random register value within a range
    function automatic logic [npms_pkg::COORD_WIDTH-1:0] rand_reg(int unsigned lo,
                                                                  int unsigned hi);
        return npms_pkg::COORD_WIDTH'($urandom_range(lo, hi));
    endfunction

    // judge one accepted word against the kept point, queue a result on the last word
    task automatic judge_point(npms_pkg::t_in_word w);
        longint unsigned d;
        longint unsigned mo;
        npms_pkg::t_out_word r;
        d = sq_offset(set_ref_x, w.point_x) + sq_offset(set_ref_y, w.point_y)
            + sq_offset(set_ref_z, w.point_z);
        mo = 64'(set_min_offset);
        if (d >= mo * mo && (!kept_any || d < kept_dist)) begin
            kept_any = 1'b1;
            kept_dist = d;
            kept_x = w.point_x;
            kept_y = w.point_y;
            kept_z = w.point_z;
        end
        if (w.last_point) begin
            r.found = kept_any;
            r.nearest_x = kept_any ? kept_x : '0;
            r.nearest_y = kept_any ? kept_y : '0;
            r.nearest_z = kept_any ? kept_z : '0;
            nearest_q.push_back(r);
            kept_any = 1'b0;
            kept_dist = 0;
            kept_x = '0;
            kept_y = '0;
            kept_z = '0;
        end
    endtask

    task automatic send_word(npms_pkg::t_in_word w);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
        judge_point(w);
        words_sent++;
    endtask

    // lower valid, let every result arrive, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (nearest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(npms_pkg::t_cfg_reg idx, logic [npms_pkg::COORD_WIDTH-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            npms_pkg::REG_REF_X: set_ref_x = value;
            npms_pkg::REG_REF_Y: set_ref_y = value;
            npms_pkg::REG_REF_Z: set_ref_z = value;
            npms_pkg::REG_MIN_OFFSET: set_min_offset = value;
            default: ;
        endcase
    endtask

    task automatic configure(logic [npms_pkg::COORD_WIDTH-1:0] rx,
                             logic [npms_pkg::COORD_WIDTH-1:0] ry,
                             logic [npms_pkg::COORD_WIDTH-1:0] rz,
                             logic [npms_pkg::COORD_WIDTH-1:0] mo);
        settle();
        write_reg(npms_pkg::REG_REF_X, rx);
        write_reg(npms_pkg::REG_REF_Y, ry);
        write_reg(npms_pkg::REG_REF_Z, rz);
        write_reg(npms_pkg::REG_MIN_OFFSET, mo);
    endtask

    // mostly points near the reference so the offset and the ordering matter
    function automatic npms_pkg::t_coord pick_coord(npms_pkg::t_coord centre, int spread);
        if ($urandom_range(0, 3) == 0)
            return npms_pkg::t_coord'($urandom());
        return centre + npms_pkg::t_coord'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_searches(int n_words, int spread);
        int sent;
        int len;
        npms_pkg::t_in_word w;
        sent = 0;
        while (sent < n_words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                w = make_word(pick_coord(set_ref_x, spread), pick_coord(set_ref_y, spread),
                              pick_coord(set_ref_z, spread), k == len - 1);
                send_word(w);
            end
            sent += len;
        end
    endtask

    task automatic test_reset_values();
        send_word(make_word(0, 0, 0, 1'b1));
        send_word(make_word(1, 0, 0, 1'b0));
        send_word(make_word(0, 0, 0, 1'b1));
    endtask

    task automatic test_extremes();
        configure(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'hffffff);
        // farthest corner passes the largest offset, the reference itself does not
        send_word(make_word(24'sh800000, 24'sh800000, 24'sh800000, 1'b1));
        send_word(make_word(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b1));
        // exactly on the offset boundary
        send_word(make_word(24'sh7fffff, 24'sh7fffff, 24'sh800000, 1'b1));
        configure(24'h800000, 24'h800000, 24'h800000, 24'h000000);
        send_word(make_word(24'sh7fffff, 24'sh000000, 24'sh800000, 1'b0));
        send_word(make_word(24'sh800000, 24'sh7fffff, 24'shffffff, 1'b1));
    endtask

    task automatic test_offset_boundary();
        configure(24'h0, 24'h0, 24'h0, 24'd5);
        send_word(make_word(3, 3, 0, 1'b1));
        send_word(make_word(3, 4, 0, 1'b1));
        send_word(make_word(3, 3, 0, 1'b0));
        send_word(make_word(0, 0, -5, 1'b1));
    endtask

    task automatic test_order_and_ties();
        configure(24'h0, 24'h0, 24'h0, 24'h0);
        // equal distances: the earlier point stays
        send_word(make_word(2, 0, 0, 1'b0));
        send_word(make_word(0, 0, -2, 1'b1));
        send_word(make_word(5, 0, 0, 1'b0));
        send_word(make_word(3, 0, 0, 1'b0));
        send_word(make_word(4, 0, 0, 1'b1));
    endtask

    task automatic test_nothing_found();
        configure(24'd100, 24'hffff9c, 24'h0, 24'd1000);
        send_word(make_word(100, -100, 0, 1'b0));
        send_word(make_word(120, -90, 7, 1'b1));
    endtask

    task automatic test_write_mid_search();
        configure(24'h0, 24'h0, 24'h0, 24'h0);
        send_word(make_word(10, 0, 0, 1'b0));
        settle();
        // kept point survives a tighter offset written mid search
        write_reg(npms_pkg::REG_MIN_OFFSET, 24'd20);
        send_word(make_word(1, 0, 0, 1'b1));
    endtask

    task automatic test_random_settings();
        configure(rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff),
                  24'h0);
        random_searches(120, 64);
        configure(rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff),
                  rand_reg(0, 200));
        random_searches(120, 128);
        configure(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'hffffff);
        random_searches(120, 256);
        configure(24'h800000, 24'h800000, 24'h800000, 24'h0);
        gapless = 1;
        random_searches(120, 32);
        gapless = 0;
        configure(rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff),
                  rand_reg(0, 24'hffffff));
        random_searches(120, 2048);
        configure(rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff), rand_reg(0, 24'hffffff),
                  rand_reg(0, 2000));
        random_searches(120, 2048);
    endtask

    task automatic test_output_backpressure();
        settle();
        gapless = 1;
        hold_off = 300;
        for (int k = 0; k < 40; k++)
            send_word(make_word(pick_coord(set_ref_x, 64), pick_coord(set_ref_y, 64),
                                pick_coord(set_ref_z, 64), 1'b1));
        gapless = 0;
    endtask

    // receiver: random stall per word, one long hold when asked
    initial begin
        int stall;
        out_ready = 1'b0;
        forever begin
            stall = gapless ? 0 : $urandom_range(0, 17);
            if (hold_off > 0) begin
                stall = hold_off;
                hold_off = 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic report_mismatch(string what, longint expected, longint got);
        $display("mismatch on %s: expected %0h, got %0h", what, expected, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        npms_pkg::t_out_word e;
        if (rst_n && o_out_valid && out_ready) begin
            if (nearest_q.size() == 0) begin
                report_mismatch("unexpected result word", 0, 64'(o_out_data));
            end else begin
                e = nearest_q.pop_front();
                results_seen++;
                if (e.found) results_found++;
                if (o_out_data.found !== e.found)
                    report_mismatch("found", longint'(e.found), longint'(o_out_data.found));
                if (o_out_data.nearest_x !== e.nearest_x)
                    report_mismatch("nearest_x", longint'(e.nearest_x),
                                    longint'(o_out_data.nearest_x));
                if (o_out_data.nearest_y !== e.nearest_y)
                    report_mismatch("nearest_y", longint'(e.nearest_y),
                                    longint'(o_out_data.nearest_y));
                if (o_out_data.nearest_z !== e.nearest_z)
                    report_mismatch("nearest_z", longint'(e.nearest_z),
                                    longint'(o_out_data.nearest_z));
            end
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = npms_pkg::REG_REF_X;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        set_ref_x = '0;
        set_ref_y = '0;
        set_ref_z = '0;
        set_min_offset = '0;
        kept_any = 1'b0;
        kept_dist = 0;
        kept_x = '0;
        kept_y = '0;
        kept_z = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_extremes();
        test_offset_boundary();
        test_order_and_ties();
        test_nothing_found();
        test_write_mid_search();
        test_random_settings();
        test_output_backpressure();
        settle();

        $display("sent %0d candidate words over extreme and random reference settings",
                 words_sent);
        $display("checked %0d search results, %0d of them with a point found",
                 results_seen, results_found);
        if (errors == 0)
            $display("nearest_point_min_offset_search_test OK");
        else
            $display("nearest_point_min_offset_search_test NOT OK");
        $finish;
    end

endmodule
